/* rtl/tlwg_pkg.sv */
// Shared constants, command record and helpers for the thick line window generator.
`default_nettype none

package tlwg_pkg;

   localparam int COORD_BITS     = 10;
   localparam int MAX_THICKNESS  = 15;
   localparam int THICK_BITS     = 4;
   localparam int COLOR_BITS     = 16;
   localparam int COUNT_BITS     = 14;
   localparam int ERR_BITS       = COORD_BITS + 3;
   localparam int PROD_BITS      = COORD_BITS + THICK_BITS + 1;
   localparam int SQ_BITS        = 2 * THICK_BITS;

   localparam logic [COORD_BITS-1:0] COORD_MAX = '1;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   // Must stay a power of two: queue pointers wrap by overflow.
   localparam int QUEUE_DEPTH    = 4;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   localparam logic OP_LOAD    = 1'b0;
   localparam logic OP_ADVANCE = 1'b1;

   typedef enum logic [1:0] {
      CMD_LINE,
      CMD_SETUP,
      CMD_ADVANCE
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type                kind;
      logic                        major_is_x;
      logic [COORD_BITS-1:0]       cur_major;
      logic [COORD_BITS-1:0]       cur_minor;
      logic [COORD_BITS-1:0]       major_end;
      logic                        step_down;
      logic [COORD_BITS-1:0]       delta_major;
      logic [COORD_BITS-1:0]       delta_minor;
      logic signed [ERR_BITS-1:0]  err;
      logic [THICK_BITS-1:0]       pen;
      logic [COLOR_BITS-1:0]       color;
      logic [COORD_BITS-1:0]       win_left;
      logic [COORD_BITS-1:0]       win_top;
      logic [COORD_BITS-1:0]       win_right;
      logic [COORD_BITS-1:0]       win_bottom;
      logic [COUNT_BITS-1:0]       count;
   } cmd_type;

   // Last covered coordinate of a pen placed at base, clipped at the edge.
   function automatic logic [COORD_BITS-1:0] sat_end(input logic [COORD_BITS-1:0] base,
                                                     input logic [THICK_BITS-1:0] t);
      logic [COORD_BITS:0] e;
      e = {1'b0, base} + (COORD_BITS+1)'(t) - (COORD_BITS+1)'(1);
      return (e > {1'b0, COORD_MAX}) ? COORD_MAX : e[COORD_BITS-1:0];
   endfunction

endpackage

`default_nettype wire

/* rtl/tlwg_front.sv */
// Front end: classify each transaction and precompute line window or walk setup.
`default_nettype none

module tlwg_front
   import tlwg_pkg::*;
(
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic                  req_opcode,
   input  wire logic [COORD_BITS-1:0] req_start_x,
   input  wire logic [COORD_BITS-1:0] req_start_y,
   input  wire logic [COORD_BITS-1:0] req_end_x,
   input  wire logic [COORD_BITS-1:0] req_end_y,
   input  wire logic [THICK_BITS-1:0] req_thickness,
   input  wire logic [COLOR_BITS-1:0] req_pen_color,
   output logic                       cmd_valid,
   input  wire logic                  cmd_ready,
   output cmd_type                    cmd
);

   logic [THICK_BITS-1:0] pen;
   logic                  vertical;
   logic                  horizontal;
   logic [COORD_BITS-1:0] lo;
   logic [COORD_BITS-1:0] hi;
   logic [COORD_BITS:0]   span_p1;
   logic [PROD_BITS-1:0]  prod;
   logic [COORD_BITS-1:0] adx;
   logic [COORD_BITS-1:0] ady;
   logic                  x_major;
   logic                  swap;
   logic [COORD_BITS-1:0] ma;
   logic [COORD_BITS-1:0] mi;
   logic [COORD_BITS-1:0] mb;
   logic [COORD_BITS-1:0] nb;
   logic [COORD_BITS-1:0] dmajor;
   logic [COORD_BITS-1:0] dminor;

   assign cmd_valid = req_valid;
   assign req_ready = cmd_ready;

   always_comb begin
      // clamp pen size to 1..MAX_THICKNESS
      if (req_thickness == '0) begin
         pen = THICK_BITS'(1);
      end else if (req_thickness > THICK_BITS'(MAX_THICKNESS)) begin
         pen = THICK_BITS'(MAX_THICKNESS);
      end else begin
         pen = req_thickness;
      end

      vertical   = (req_start_x == req_end_x);
      horizontal = (req_start_y == req_end_y);

      if (vertical) begin
         lo = (req_start_y < req_end_y) ? req_start_y : req_end_y;
         hi = (req_start_y < req_end_y) ? req_end_y : req_start_y;
      end else begin
         lo = (req_start_x < req_end_x) ? req_start_x : req_end_x;
         hi = (req_start_x < req_end_x) ? req_end_x : req_start_x;
      end
      span_p1 = {1'b0, hi - lo} + (COORD_BITS+1)'(1);
      prod    = PROD_BITS'(pen) * PROD_BITS'(span_p1);

      adx     = (req_start_x > req_end_x) ? req_start_x - req_end_x : req_end_x - req_start_x;
      ady     = (req_start_y > req_end_y) ? req_start_y - req_end_y : req_end_y - req_start_y;
      x_major = (ady < adx);
      swap    = x_major ? (req_start_x > req_end_x) : (req_start_y > req_end_y);
      if (x_major) begin
         ma = swap ? req_end_x   : req_start_x;
         mi = swap ? req_end_y   : req_start_y;
         mb = swap ? req_start_x : req_end_x;
         nb = swap ? req_start_y : req_end_y;
      end else begin
         ma = swap ? req_end_y   : req_start_y;
         mi = swap ? req_end_x   : req_start_x;
         mb = swap ? req_start_y : req_end_y;
         nb = swap ? req_start_x : req_end_x;
      end
      dmajor = mb - ma;
      dminor = x_major ? ady : adx;

      cmd.major_is_x  = x_major;
      cmd.cur_major   = ma;
      cmd.cur_minor   = mi;
      cmd.major_end   = mb;
      cmd.step_down   = (nb < mi);
      cmd.delta_major = dmajor;
      cmd.delta_minor = dminor;
      cmd.err         = $signed(ERR_BITS'({dminor, 1'b0})) - $signed(ERR_BITS'(dmajor));
      cmd.pen         = pen;
      cmd.color       = req_pen_color;

      if (vertical) begin
         cmd.win_left   = req_start_x;
         cmd.win_top    = lo;
         cmd.win_right  = sat_end(req_start_x, pen);
         cmd.win_bottom = hi;
      end else begin
         cmd.win_left   = lo;
         cmd.win_top    = req_start_y;
         cmd.win_right  = hi;
         cmd.win_bottom = sat_end(req_start_y, pen);
      end
      cmd.count = (prod > PROD_BITS'(COUNT_MAX)) ? COUNT_MAX : prod[COUNT_BITS-1:0];

      if (req_opcode == OP_ADVANCE) begin
         cmd.kind = CMD_ADVANCE;
      end else if (vertical || horizontal) begin
         cmd.kind = CMD_LINE;
      end else begin
         cmd.kind = CMD_SETUP;
      end
   end

endmodule

`default_nettype wire

/* rtl/tlwg_queue.sv */
// Short command queue between the front end and the walk unit.
`default_nettype none

module tlwg_queue
   import tlwg_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    in_valid,
   output logic         in_ready,
   input  wire cmd_type in_cmd,
   output logic         out_valid,
   input  wire logic    out_ready,
   output cmd_type      out_cmd
);

   cmd_type                   entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_BITS-1:0] count_ff, count_in;
   logic                      push;
   logic                      pop;

   assign in_ready  = (count_ff != QUEUE_CNT_BITS'(QUEUE_DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_cmd   = entry_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QUEUE_PTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + QUEUE_PTR_BITS'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QUEUE_CNT_BITS'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QUEUE_CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= in_cmd;
      end
   end

endmodule

`default_nettype wire

/* rtl/tlwg_back.sv */
// Back end: Bresenham walk state and the registered window output.
`default_nettype none

module tlwg_back
   import tlwg_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   cmd_valid,
   output logic                        cmd_ready,
   input  wire cmd_type                cmd,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic [COORD_BITS-1:0]       rsp_win_left,
   output logic [COORD_BITS-1:0]       rsp_win_top,
   output logic [COORD_BITS-1:0]       rsp_win_right,
   output logic [COORD_BITS-1:0]       rsp_win_bottom,
   output logic [COUNT_BITS-1:0]       rsp_pixel_count,
   output logic [COLOR_BITS-1:0]       rsp_fill_color,
   output logic                        rsp_last
);

   logic                       walking_ff, walking_in;
   logic                       major_is_x_ff, major_is_x_in;
   logic [COORD_BITS-1:0]      cur_major_ff, cur_major_in;
   logic [COORD_BITS-1:0]      cur_minor_ff, cur_minor_in;
   logic [COORD_BITS-1:0]      major_end_ff, major_end_in;
   logic                       step_down_ff, step_down_in;
   logic [COORD_BITS-1:0]      delta_major_ff, delta_major_in;
   logic [COORD_BITS-1:0]      delta_minor_ff, delta_minor_in;
   logic signed [ERR_BITS-1:0] err_ff, err_in;
   logic [THICK_BITS-1:0]      pen_ff, pen_in;
   logic [COLOR_BITS-1:0]      color_ff, color_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic [COORD_BITS-1:0]      left_ff, left_in;
   logic [COORD_BITS-1:0]      top_ff, top_in;
   logic [COORD_BITS-1:0]      right_ff, right_in;
   logic [COORD_BITS-1:0]      bottom_ff, bottom_in;
   logic [COUNT_BITS-1:0]      count_ff, count_in;
   logic [COLOR_BITS-1:0]      fill_ff, fill_in;
   logic                       last_ff, last_in;

   logic                       pop;
   logic [COORD_BITS-1:0]      pt_x;
   logic [COORD_BITS-1:0]      pt_y;
   logic                       fin;
   logic [SQ_BITS-1:0]         square;
   logic signed [ERR_BITS-1:0] err_step;

   assign cmd_ready = !rsp_valid_ff || rsp_ready;
   assign pop       = cmd_valid && cmd_ready;

   assign pt_x   = major_is_x_ff ? cur_major_ff : cur_minor_ff;
   assign pt_y   = major_is_x_ff ? cur_minor_ff : cur_major_ff;
   assign fin    = (cur_major_ff >= major_end_ff);
   assign square = SQ_BITS'(pen_ff) * SQ_BITS'(pen_ff);

   always_comb begin
      err_step = err_ff + $signed(ERR_BITS'({delta_minor_ff, 1'b0}));
      if (err_ff > 0) begin
         err_step = err_step - $signed(ERR_BITS'({delta_major_ff, 1'b0}));
      end
   end

   always_comb begin
      walking_in     = walking_ff;
      major_is_x_in  = major_is_x_ff;
      cur_major_in   = cur_major_ff;
      cur_minor_in   = cur_minor_ff;
      major_end_in   = major_end_ff;
      step_down_in   = step_down_ff;
      delta_major_in = delta_major_ff;
      delta_minor_in = delta_minor_ff;
      err_in         = err_ff;
      pen_in         = pen_ff;
      color_in       = color_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      left_in        = left_ff;
      top_in         = top_ff;
      right_in       = right_ff;
      bottom_in      = bottom_ff;
      count_in       = count_ff;
      fill_in        = fill_ff;
      last_in        = last_ff;

      if (pop) begin
         case (cmd.kind)
            CMD_LINE: begin
               walking_in   = 1'b0;
               pen_in       = cmd.pen;
               color_in     = cmd.color;
               rsp_valid_in = 1'b1;
               left_in      = cmd.win_left;
               top_in       = cmd.win_top;
               right_in     = cmd.win_right;
               bottom_in    = cmd.win_bottom;
               count_in     = cmd.count;
               fill_in      = cmd.color;
               last_in      = 1'b1;
            end
            CMD_SETUP: begin
               walking_in     = 1'b1;
               major_is_x_in  = cmd.major_is_x;
               cur_major_in   = cmd.cur_major;
               cur_minor_in   = cmd.cur_minor;
               major_end_in   = cmd.major_end;
               step_down_in   = cmd.step_down;
               delta_major_in = cmd.delta_major;
               delta_minor_in = cmd.delta_minor;
               err_in         = cmd.err;
               pen_in         = cmd.pen;
               color_in       = cmd.color;
               rsp_valid_in   = 1'b0;
            end
            CMD_ADVANCE: begin
               rsp_valid_in = walking_ff;
               if (walking_ff) begin
                  left_in   = pt_x;
                  top_in    = pt_y;
                  right_in  = sat_end(pt_x, pen_ff);
                  bottom_in = sat_end(pt_y, pen_ff);
                  count_in  = COUNT_BITS'(square);
                  fill_in   = color_ff;
                  last_in   = fin;
                  if (fin) begin
                     walking_in = 1'b0;
                  end else begin
                     if (err_ff > 0) begin
                        cur_minor_in = step_down_ff ? cur_minor_ff - COORD_BITS'(1)
                                                    : cur_minor_ff + COORD_BITS'(1);
                     end
                     err_in       = err_step;
                     cur_major_in = cur_major_ff + COORD_BITS'(1);
                  end
               end
            end
            default: begin
               rsp_valid_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         walking_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         walking_ff   <= walking_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      major_is_x_ff  <= major_is_x_in;
      cur_major_ff   <= cur_major_in;
      cur_minor_ff   <= cur_minor_in;
      major_end_ff   <= major_end_in;
      step_down_ff   <= step_down_in;
      delta_major_ff <= delta_major_in;
      delta_minor_ff <= delta_minor_in;
      err_ff         <= err_in;
      pen_ff         <= pen_in;
      color_ff       <= color_in;
      left_ff        <= left_in;
      top_ff         <= top_in;
      right_ff       <= right_in;
      bottom_ff      <= bottom_in;
      count_ff       <= count_in;
      fill_ff        <= fill_in;
      last_ff        <= last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_win_left    = left_ff;
   assign rsp_win_top     = top_ff;
   assign rsp_win_right   = right_ff;
   assign rsp_win_bottom  = bottom_ff;
   assign rsp_pixel_count = count_ff;
   assign rsp_fill_color  = fill_ff;
   assign rsp_last        = last_ff;

   a_line_emits_last: assert property (@(posedge clock) disable iff (reset)
      pop && (cmd.kind == CMD_LINE) |=> rsp_valid_ff && last_ff)
      else $error("straight line did not produce a last window");

   a_setup_starts_walk: assert property (@(posedge clock) disable iff (reset)
      pop && (cmd.kind == CMD_SETUP) |=> walking_ff && !rsp_valid_ff)
      else $error("walk setup did not start a walk silently");

   a_mid_window_walking: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !last_ff |-> walking_ff)
      else $error("non-final window outside a walk");

   a_major_advances: assert property (@(posedge clock) disable iff (reset)
      pop && (cmd.kind == CMD_ADVANCE) && walking_ff && !fin
      |=> cur_major_ff == $past(cur_major_ff) + COORD_BITS'(1))
      else $error("major coordinate did not advance by one");

endmodule

`default_nettype wire

/* rtl/thick_line_window_generator_top.sv */
// Top level of the thick line window generator: front end, command queue, walk unit.
`default_nettype none

// Thick line window generator. Each req_ transaction either loads a line
// (opcode 0) or asks for the next point of the current line (opcode 1).
// A vertical line (equal columns, which includes a single point) or a
// horizontal line returns one fill window with last set right on load,
// with pixel_count = thickness * (span + 1). Any other line returns nothing
// on load and starts a Bresenham walk from the lower to the higher major
// coordinate; every advance then returns one thickness-by-thickness window
// at the current point, with pixel_count = thickness squared and last set
// on the final point. Advances while no walk is active return nothing, and a
// new load abandons any walk in progress. Thickness 0 is taken as 1; right
// and bottom window edges clip at the last coordinate while the pixel count
// is not reduced. Rate: one transaction per clock cycle sustained while
// rsp_ready stays high, set by the single add-and-compare step of the walk
// unit per point. A result passes through the command queue and then the
// output register before it appears on rsp_. The front end classifies and
// precomputes each transaction, a four-entry queue decouples it from the
// walk unit, and the queue keeps accepting requests while a window waits
// for rsp_ready, until it is full.
module thick_line_window_generator_top
   import tlwg_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic                  req_opcode,
   input  wire logic [COORD_BITS-1:0] req_start_x,
   input  wire logic [COORD_BITS-1:0] req_start_y,
   input  wire logic [COORD_BITS-1:0] req_end_x,
   input  wire logic [COORD_BITS-1:0] req_end_y,
   input  wire logic [THICK_BITS-1:0] req_thickness,
   input  wire logic [COLOR_BITS-1:0] req_pen_color,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [COORD_BITS-1:0]      rsp_win_left,
   output logic [COORD_BITS-1:0]      rsp_win_top,
   output logic [COORD_BITS-1:0]      rsp_win_right,
   output logic [COORD_BITS-1:0]      rsp_win_bottom,
   output logic [COUNT_BITS-1:0]      rsp_pixel_count,
   output logic [COLOR_BITS-1:0]      rsp_fill_color,
   output logic                       rsp_last
);

   // classified transactions from the front end into the queue
   logic    front_valid;
   logic    front_ready;
   cmd_type front_cmd;

   // queued transactions toward the walk unit
   logic    queue_valid;
   logic    queue_ready;
   cmd_type queue_cmd;

   // Classify each request and precompute the straight window or walk setup.
   tlwg_front u_front (
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_opcode    (req_opcode),
      .req_start_x   (req_start_x),
      .req_start_y   (req_start_y),
      .req_end_x     (req_end_x),
      .req_end_y     (req_end_y),
      .req_thickness (req_thickness),
      .req_pen_color (req_pen_color),
      .cmd_valid     (front_valid),
      .cmd_ready     (front_ready),
      .cmd           (front_cmd)
   );

   // Hold commands while the output side stalls.
   tlwg_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_cmd    (front_cmd),
      .out_valid (queue_valid),
      .out_ready (queue_ready),
      .out_cmd   (queue_cmd)
   );

   // Advance the walk and register each window for the result channel.
   tlwg_back u_back (
      .clock           (clock),
      .reset           (reset),
      .cmd_valid       (queue_valid),
      .cmd_ready       (queue_ready),
      .cmd             (queue_cmd),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_win_left    (rsp_win_left),
      .rsp_win_top     (rsp_win_top),
      .rsp_win_right   (rsp_win_right),
      .rsp_win_bottom  (rsp_win_bottom),
      .rsp_pixel_count (rsp_pixel_count),
      .rsp_fill_color  (rsp_fill_color),
      .rsp_last        (rsp_last)
   );

endmodule

`default_nettype wire
